>>> src/msq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_pkg: shared types and tables for the marching squares cell unit
// Payload structs, edge codes and the per-code edge lists.
// ----------------------------------------------------------------------------
package msq_pkg;

    localparam int VW = 16;
    localparam int CW = 16;
    localparam int FW = 16;

    typedef enum logic [1:0] {
        EDGE_TOP    = 2'd0,
        EDGE_RIGHT  = 2'd1,
        EDGE_BOTTOM = 2'd2,
        EDGE_LEFT   = 2'd3
    } edge_t;

    // Crossing datapath states.
    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_MUL, ST_OUT} bst_t;

    typedef struct packed {
        logic signed [VW-1:0] value_top_left;
        logic signed [VW-1:0] value_top_right;
        logic signed [VW-1:0] value_bottom_right;
        logic signed [VW-1:0] value_bottom_left;
        logic signed [CW-1:0] top_left_x;
        logic signed [CW-1:0] top_left_y;
        logic signed [CW-1:0] top_right_x;
        logic signed [CW-1:0] top_right_y;
        logic signed [CW-1:0] bottom_right_x;
        logic signed [CW-1:0] bottom_right_y;
        logic signed [CW-1:0] bottom_left_x;
        logic signed [CW-1:0] bottom_left_y;
    } cell_t;

    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic [1:0]           edge_id;
        logic                 last_point;
    } point_t;

    // One crossing job handed from front to back.
    typedef struct packed {
        logic signed [VW-1:0] vs;
        logic signed [VW-1:0] ve;
        logic signed [VW-1:0] iso;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] xe;
        logic signed [CW-1:0] ys;
        logic signed [CW-1:0] ye;
        logic [1:0]           edge_id;
        logic                 last_point;
    } job_t;

    function automatic logic [2:0] edge_count(input logic [3:0] code);
        logic [2:0] n;
        begin
            case (code)
                4'd0, 4'd15: n = 3'd0;
                4'd5, 4'd10: n = 3'd4;
                default:     n = 3'd2;
            endcase
            return n;
        end
    endfunction

    function automatic edge_t edge_at(input logic [3:0] code, input logic [1:0] k);
        edge_t e [4];
        begin
            e = '{EDGE_TOP, EDGE_TOP, EDGE_TOP, EDGE_TOP};
            case (code)
                4'd1, 4'd14: e = '{EDGE_BOTTOM, EDGE_LEFT, EDGE_TOP, EDGE_TOP};
                4'd2, 4'd13: e = '{EDGE_BOTTOM, EDGE_RIGHT, EDGE_TOP, EDGE_TOP};
                4'd3, 4'd12: e = '{EDGE_RIGHT, EDGE_LEFT, EDGE_TOP, EDGE_TOP};
                4'd4, 4'd11: e = '{EDGE_TOP, EDGE_RIGHT, EDGE_TOP, EDGE_TOP};
                4'd5:        e = '{EDGE_TOP, EDGE_RIGHT, EDGE_BOTTOM, EDGE_LEFT};
                4'd6, 4'd9:  e = '{EDGE_BOTTOM, EDGE_TOP, EDGE_TOP, EDGE_TOP};
                4'd7, 4'd8:  e = '{EDGE_LEFT, EDGE_TOP, EDGE_TOP, EDGE_TOP};
                4'd10:       e = '{EDGE_LEFT, EDGE_TOP, EDGE_BOTTOM, EDGE_RIGHT};
                default:     e = '{EDGE_TOP, EDGE_TOP, EDGE_TOP, EDGE_TOP};
            endcase
            return e[k];
        end
    endfunction

endpackage

>>> src/marching_squares_cell_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marching_squares_cell_unit: isoline endpoints for one grid cell
// Classifies a cell by corner code, then interpolates 0, 2 or 4 crossings.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  s_      | in  | cell_t: four corner values and positions
//  m_      | out | point_t: endpoint, edge, last flag
//  cfg_    | in  | iso_level write
// Front issues one crossing job per cycle into a two-entry queue while it has room.
// Back handles each endpoint as a load, 33 divide steps, a multiply and an
// output, cutting the divide short when the fraction is forced to zero, and takes
// no new job until its output step is done; a cell without crossings is dropped.
// Reset clears control only; iso_level resets to 0.
// Either side stalls on its own; the output register holds under m_ready low.
module marching_squares_cell_unit import msq_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [VW-1:0] cfg_data,
    input  logic          s_valid,
    output logic          s_ready,
    input  cell_t         s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output point_t        m_data
);

    logic [VW-1:0] iso_reg;
    logic f_valid, f_ready, b_valid, b_ready;
    job_t f_job, b_job;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) iso_reg <= '0;
        else if (cfg_valid) iso_reg <= cfg_data;
    end

    msq_front u_front (.aclk, .aresetn, .iso_level(iso_reg), .s_valid, .s_ready,
        .s_data, .job_valid(f_valid), .job_ready(f_ready), .job(f_job));
    msq_fifo u_fifo (.aclk, .aresetn, .in_valid(f_valid), .in_ready(f_ready),
        .in_job(f_job), .out_valid(b_valid), .out_ready(b_ready), .out_job(b_job));
    msq_back u_back (.aclk, .aresetn, .job_valid(b_valid), .job_ready(b_ready),
        .job(b_job), .m_valid, .m_ready, .m_data);

endmodule

>>> src/msq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_front: cell classifier
// Registers a cell, forms its code and issues one crossing job per cycle while the queue accepts.
// ----------------------------------------------------------------------------
module msq_front import msq_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [VW-1:0]    iso_level,
    input  logic             s_valid,
    output logic             s_ready,
    input  cell_t            s_data,
    output logic             job_valid,
    input  logic             job_ready,
    output job_t             job
);

    logic       busy_reg, busy_next;
    cell_t      cell_reg;
    logic [3:0] code_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] idx_reg, idx_next;
    logic [3:0] code_in;
    logic       take, issue, done;
    edge_t      e;
    logic signed [VW-1:0] v [4];
    logic signed [CW-1:0] px [4];
    logic signed [CW-1:0] py [4];
    logic [1:0] si, ei;

    assign code_in = {$signed(s_data.value_top_left) > $signed(iso_level),
                      $signed(s_data.value_top_right) > $signed(iso_level),
                      $signed(s_data.value_bottom_right) > $signed(iso_level),
                      $signed(s_data.value_bottom_left) > $signed(iso_level)};

    assign issue = busy_reg && job_ready;
    assign done  = issue && ({1'b0, idx_reg} == cnt_reg - 3'd1);
    assign s_ready = !busy_reg || done;
    assign take  = s_valid && s_ready && (edge_count(code_in) != 3'd0);

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        idx_next  = idx_reg;
        if (issue) idx_next = idx_reg + 2'd1;
        if (done) busy_next = 1'b0;
        if (take) begin
            busy_next = 1'b1;
            cnt_next  = edge_count(code_in);
            idx_next  = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            idx_reg  <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            idx_reg  <= idx_next;
        end
        if (take) begin
            cell_reg <= s_data;
            code_reg <= code_in;
        end
    end

    // The user must change iso_level only while idle; the block does not enforce this. It is sampled live.
    always_comb begin
        v  = '{cell_reg.value_top_left, cell_reg.value_top_right,
               cell_reg.value_bottom_right, cell_reg.value_bottom_left};
        px = '{cell_reg.top_left_x, cell_reg.top_right_x,
               cell_reg.bottom_right_x, cell_reg.bottom_left_x};
        py = '{cell_reg.top_left_y, cell_reg.top_right_y,
               cell_reg.bottom_right_y, cell_reg.bottom_left_y};
        e  = edge_at(code_reg, idx_reg);
        case (e)
            EDGE_TOP:    begin si = 2'd0; ei = 2'd1; end
            EDGE_RIGHT:  begin si = 2'd1; ei = 2'd2; end
            EDGE_BOTTOM: begin si = 2'd3; ei = 2'd2; end
            default:     begin si = 2'd0; ei = 2'd3; end
        endcase
        job.vs = v[si];
        job.ve = v[ei];
        job.iso = iso_level;
        job.xs = px[si];
        job.xe = px[ei];
        job.ys = py[si];
        job.ye = py[ei];
        job.edge_id = e;
        job.last_point = ({1'b0, idx_reg} == cnt_reg - 3'd1);
    end

    assign job_valid = busy_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cnt_reg == 3'd2 || cnt_reg == 3'd4))
        else $error("bad edge count");
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> ({1'b0, idx_reg} < cnt_reg))
        else $error("edge index overrun");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !job_ready) |=> busy_reg && $stable(idx_reg))
        else $error("job lost under stall");

endmodule

>>> src/msq_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_fifo: short job queue
// Two-entry register queue parting the classifier from the datapath.
// ----------------------------------------------------------------------------
module msq_fifo import msq_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    output logic out_valid,
    input  logic out_ready,
    output job_t out_job
);

    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_job   = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) mem_reg[wp_reg] <= in_job;
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn) !in_ready |-> out_valid)
        else $error("queue full but empty");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> out_valid && $stable(out_job))
        else $error("queue head changed under stall");

endmodule

>>> src/msq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_back: crossing datapath
// Radix-2 divider for the edge fraction, then a two-step lerp on x and y.
// ----------------------------------------------------------------------------
module msq_back import msq_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   job_valid,
    output logic   job_ready,
    input  job_t   job,
    output logic   m_valid,
    input  logic   m_ready,
    output point_t m_data
);

    localparam int DW = VW + 1;
    localparam int QW = FW + 1;

    bst_t st_reg, st_next;
    job_t j_reg;
    logic [DW-1:0] rem_reg, dm_reg;
    logic [QW+DW-1:0] q_reg;
    logic [5:0] bit_reg;
    logic zero_reg;
    logic signed [CW+QW:0] px_reg, py_reg;
    point_t out_reg;
    logic out_valid_reg;

    logic signed [DW-1:0] num, den;
    logic [DW-1:0] nm, dm;
    logic [DW:0] trial;
    logic [QW-1:0] t;
    logic signed [CW:0] dx, dy;
    logic signed [CW+QW:0] offx, offy;
    logic out_free;

    assign num = DW'(job.vs) - DW'(job.iso);
    assign den = DW'(job.vs) - DW'(job.ve);
    assign nm  = num[DW-1] ? DW'(-num) : num;
    assign dm  = den[DW-1] ? DW'(-den) : den;

    assign out_free = !out_valid_reg || m_ready;
    assign job_ready = (st_reg == ST_IDLE);
    assign trial = {rem_reg, q_reg[QW+DW-1]} - {1'b0, dm_reg};
    assign t = (q_reg[QW+DW-1:QW] != '0 || q_reg[QW-1:0] > QW'(1 << FW))
               ? QW'(1 << FW) : q_reg[QW-1:0];
    assign dx = (CW+1)'(j_reg.xe) - (CW+1)'(j_reg.xs);
    assign dy = (CW+1)'(j_reg.ye) - (CW+1)'(j_reg.ys);

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: if (job_valid) st_next = ST_DIV;
            ST_DIV:  if (bit_reg == 6'd0 || zero_reg) st_next = ST_MUL;
            ST_MUL:  st_next = ST_OUT;
            ST_OUT:  if (out_free) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    // floor division of the products by 2^FW, for both signs
    always_comb begin
        offx = (px_reg >>> FW);
        offy = (py_reg >>> FW);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (m_ready) out_valid_reg <= 1'b0;
            if (st_reg == ST_OUT && out_free) out_valid_reg <= 1'b1;
        end
        case (st_reg)
            ST_IDLE: begin
                j_reg   <= job;
                dm_reg  <= dm;
                rem_reg <= '0;
                q_reg   <= {nm, {QW{1'b0}}};
                bit_reg <= 6'(DW + FW - 1);
                zero_reg <= (den == '0) || (num != '0 && (num[DW-1] != den[DW-1]));
            end
            ST_DIV: begin
                if (!trial[DW]) rem_reg <= trial[DW-1:0];
                else rem_reg <= {rem_reg[DW-2:0], q_reg[QW+DW-1]};
                q_reg <= {q_reg[QW+DW-2:0], !trial[DW]};
                bit_reg <= bit_reg - 6'd1;
            end
            ST_MUL: begin
                if (zero_reg) begin
                    px_reg <= '0;
                    py_reg <= '0;
                end else begin
                    px_reg <= dx * $signed({1'b0, t});
                    py_reg <= dy * $signed({1'b0, t});
                end
            end
            ST_OUT: if (out_free) begin
                out_reg.point_x <= CW'(j_reg.xs + CW'(offx));
                out_reg.point_y <= CW'(j_reg.ys + CW'(offy));
                out_reg.edge_id <= j_reg.edge_id;
                out_reg.last_point <= j_reg.last_point;
            end
            default: ;
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_data))
        else $error("result changed under stall");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_DIV) |-> (bit_reg <= 6'(DW + FW - 1)))
        else $error("divide step out of range");

endmodule

>>> dv/msq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_checker: endpoint predictor and scoreboard for the cell unit
// Watches the cell, point and iso_level channels, predicts endpoints per cell
// and compares each emitted endpoint with the oldest prediction.
// ----------------------------------------------------------------------------
module msq_checker import msq_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  logic [VW-1:0] cfg_data,
    input  logic          s_valid,
    input  logic          s_ready,
    input  cell_t         s_data,
    input  logic          m_valid,
    input  logic          m_ready,
    input  point_t        m_data,
    output int            fail_count,
    output int            pending
);

    point_t           point_queue[$];
    logic signed [VW-1:0] iso_shadow;

    assign pending = point_queue.size();

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic longint crossing_fraction(longint vs, longint ve, longint iso);
        longint num;
        longint den;
        longint q;
        num = vs - iso;
        den = vs - ve;
        if (den == 0) return 0;
        if (((num < 0) != (den < 0)) && num != 0) return 0;
        if (num < 0) num = -num;
        if (den < 0) den = -den;
        q = (num <<< FW) / den;
        return (q > (64'sd1 <<< FW)) ? (64'sd1 <<< FW) : q;
    endfunction

    function automatic logic [CW-1:0] blend_coord(longint ps, longint pe, longint t);
        longint prod;
        longint off;
        prod = (pe - ps) * t;
        // floor division by 2^FW, for both signs
        off = prod >>> FW;
        return CW'(ps + off);
    endfunction

    task automatic predict_cell(input cell_t c);
        longint val[4];
        longint px[4];
        longint py[4];
        logic [3:0] code;
        int n;
        edge_t e;
        int s;
        int d;
        longint t;
        point_t p;
        val = '{c.value_top_left, c.value_top_right, c.value_bottom_right,
                c.value_bottom_left};
        px = '{c.top_left_x, c.top_right_x, c.bottom_right_x, c.bottom_left_x};
        py = '{c.top_left_y, c.top_right_y, c.bottom_right_y, c.bottom_left_y};
        for (int i = 0; i < 4; i++) code[3-i] = val[i] > longint'(iso_shadow);
        n = (code == 4'd0 || code == 4'd15) ? 0 : ((code == 4'd5 || code == 4'd10) ? 4 : 2);
        for (int i = 0; i < n; i++) begin
            case (code)
                4'd1, 4'd14: e = (i == 0) ? EDGE_BOTTOM : EDGE_LEFT;
                4'd2, 4'd13: e = (i == 0) ? EDGE_BOTTOM : EDGE_RIGHT;
                4'd3, 4'd12: e = (i == 0) ? EDGE_RIGHT : EDGE_LEFT;
                4'd4, 4'd11: e = (i == 0) ? EDGE_TOP : EDGE_RIGHT;
                4'd6, 4'd9:  e = (i == 0) ? EDGE_BOTTOM : EDGE_TOP;
                4'd7, 4'd8:  e = (i == 0) ? EDGE_LEFT : EDGE_TOP;
                4'd5: begin
                    case (i)
                        0: e = EDGE_TOP;
                        1: e = EDGE_RIGHT;
                        2: e = EDGE_BOTTOM;
                        default: e = EDGE_LEFT;
                    endcase
                end
                default: begin
                    case (i)
                        0: e = EDGE_LEFT;
                        1: e = EDGE_TOP;
                        2: e = EDGE_BOTTOM;
                        default: e = EDGE_RIGHT;
                    endcase
                end
            endcase
            case (e)
                EDGE_TOP:    begin s = 0; d = 1; end
                EDGE_RIGHT:  begin s = 1; d = 2; end
                EDGE_BOTTOM: begin s = 3; d = 2; end
                default:     begin s = 0; d = 3; end
            endcase
            t = crossing_fraction(val[s], val[d], longint'(iso_shadow));
            p.point_x    = blend_coord(px[s], px[d], t);
            p.point_y    = blend_coord(py[s], py[d], t);
            p.edge_id    = e;
            p.last_point = (i == n - 1);
            point_queue.push_back(p);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            iso_shadow <= '0;
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (point_queue.size() == 0) begin
                    report_mismatch("endpoint with none expected");
                end else begin
                    point_t want;
                    want = point_queue.pop_front();
                    if (m_data.point_x !== want.point_x)
                        report_mismatch($sformatf("point_x %h want %h", m_data.point_x,
                                                  want.point_x));
                    if (m_data.point_y !== want.point_y)
                        report_mismatch($sformatf("point_y %h want %h", m_data.point_y,
                                                  want.point_y));
                    if (m_data.edge_id !== want.edge_id)
                        report_mismatch($sformatf("edge_id %0d want %0d", m_data.edge_id,
                                                  want.edge_id));
                    if (m_data.last_point !== want.last_point)
                        report_mismatch($sformatf("last_point %b want %b",
                                                  m_data.last_point, want.last_point));
                end
            end
            if (s_valid && s_ready) predict_cell(s_data);
            if (cfg_valid && cfg_ready) iso_shadow <= cfg_data;
        end
    end

endmodule

>>> dv/tb_marching_squares_cell_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_marching_squares_cell_unit: stimulus and verdict for the cell unit
// Drives directed and random cells through several iso levels under random
// idling on both channels in all but the last phase; the checker predicts and scores every endpoint.
// ----------------------------------------------------------------------------
module tb_marching_squares_cell_unit;
    import msq_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic          aclk;
    logic          aresetn;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [VW-1:0] cfg_data;
    logic          s_valid;
    logic          s_ready;
    cell_t         s_data;
    logic          m_valid;
    logic          m_ready;
    point_t        m_data;
    int            fail_count;
    int            pending;
    int            sender_idle_pct;
    int            receiver_idle_pct;
    int            quiet_cycles;

    marching_squares_cell_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    msq_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: decide ready at each falling edge from the current idle rate.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Watchdog: count cycles where no channel moves an item.
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress in %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Send one cell; hold valid and payload until accepted. Valid stays high
    // on return so the next cell can follow back to back; the caller drops it.
    task automatic send_cell(input cell_t c);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_data  <= c;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Drain predictions, let the back end settle, then write iso_level.
    task automatic write_iso(input logic [VW-1:0] level);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        cfg_data  <= level;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand16();
        return 16'($urandom);
    endfunction

    // Random cell: corners near the iso level so crossings are common,
    // with occasional full-range noise; positions mostly a small square.
    function automatic cell_t random_cell(input logic signed [15:0] iso);
        cell_t c;
        logic signed [15:0] v[4];
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] sz;
        for (int i = 0; i < 4; i++) begin
            if ($urandom_range(9) == 0) v[i] = rand16();
            else v[i] = 16'(int'(iso) + $urandom_range(1, 2048) *
                            ($urandom_range(1) ? 1 : -1));
        end
        c.value_top_left     = v[0];
        c.value_top_right    = v[1];
        c.value_bottom_right = v[2];
        c.value_bottom_left  = v[3];
        if ($urandom_range(4) == 0) begin
            c.top_left_x = rand16();     c.top_left_y = rand16();
            c.top_right_x = rand16();    c.top_right_y = rand16();
            c.bottom_right_x = rand16(); c.bottom_right_y = rand16();
            c.bottom_left_x = rand16();  c.bottom_left_y = rand16();
        end else begin
            x0 = rand16();
            y0 = rand16();
            sz = 16'($urandom_range(1, 4096));
            c.top_left_x = x0;           c.top_left_y = y0;
            c.top_right_x = x0 + sz;     c.top_right_y = y0;
            c.bottom_right_x = x0 + sz;  c.bottom_right_y = y0 + sz;
            c.bottom_left_x = x0;        c.bottom_left_y = y0 + sz;
        end
        return c;
    endfunction

    initial begin
        cell_t c;
        logic signed [15:0] iso_now;
        logic signed [15:0] iso_levels[5];
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_data = '0;
        sender_idle_pct = 23;
        receiver_idle_pct = 74;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: every corner code at iso 0, corner extremes as values/coords.
        iso_now = 16'sd0;
        for (int code = 0; code < 16; code++) begin
            c.value_top_left     = code[3] ? 16'sh7fff : 16'sh8000;
            c.value_top_right    = code[2] ? 16'sd1    : 16'sd0;
            c.value_bottom_right = code[1] ? 16'sh0100 : -16'sh0100;
            c.value_bottom_left  = code[0] ? 16'sh4000 : -16'sh0001;
            c.top_left_x = 16'sh8000;     c.top_left_y = 16'sh8000;
            c.top_right_x = 16'sh7fff;    c.top_right_y = 16'sh8000;
            c.bottom_right_x = 16'sh7fff; c.bottom_right_y = 16'sh7fff;
            c.bottom_left_x = 16'sh8000;  c.bottom_left_y = 16'sh7fff;
            if (code[0]) begin
                c.top_left_x = 16'sh7fff; c.bottom_right_y = 16'sh8000;
            end
            send_cell(c);
        end
        // Saddles with tiny differences: fraction near the edges of its range.
        c = random_cell(iso_now);
        c.value_top_left = 16'sd1;  c.value_top_right = 16'sh8000;
        c.value_bottom_right = 16'sh7fff; c.value_bottom_left = 16'sd0;
        send_cell(c);
        c.value_top_left = 16'sh8000; c.value_top_right = 16'sd1;
        c.value_bottom_right = 16'sd0; c.value_bottom_left = 16'sh7fff;
        send_cell(c);

        // Iso extremes and typical levels, each followed by random cells.
        iso_levels = '{16'sh8000, 16'sh7fff, -16'sh0280, 16'sh0133, 16'sd0};
        for (int phase = 0; phase < 5; phase++) begin
            if (phase == 2) begin
                sender_idle_pct = 74;
                receiver_idle_pct = 23;
            end
            if (phase == 4) begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            iso_now = iso_levels[phase];
            write_iso(iso_now);
            for (int k = 0; k < ((phase < 2) ? 10 : 40); k++) begin
                c = random_cell(iso_now);
                if (phase < 2 && k < 4) c = random_cell(16'sd0);
                send_cell(c);
            end
        end

        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
